/* hw/rtl/spt_pkg.sv */
// Shared types, constants and widths for the stereo point triangulator.
package spt_pkg;

    localparam int unsigned NumRegs = 7;
    localparam int unsigned IdxW    = 3;
    localparam int unsigned CoordW  = 14;
    localparam int unsigned TagW    = 32;
    localparam int unsigned OutW    = 16;
    // Numerator magnitude bound: 2*(f*b) < 2^28, disparity 14 bits, 2*d 15 bits.
    localparam int unsigned NumW    = 29;
    localparam int unsigned DenW    = 16;
    localparam int unsigned QuoW    = 28;
    localparam int unsigned DefDivSteps = 4;

    typedef enum logic [IdxW-1:0] {
        REG_FOCAL  = 3'd0,
        REG_BASE   = 3'd1,
        REG_CX     = 3'd2,
        REG_CY     = 3'd3,
        REG_JIT    = 3'd4,
        REG_MARGIN = 3'd5,
        REG_WIDTH  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]       focal;
        logic [10:0]       base;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [CoordW-1:0] jit;
        logic [CoordW-1:0] margin;
        logic [CoordW-1:0] width;
    } t_cfg;

endpackage

/* hw/rtl/stereo_point_triangulator.sv */
// Stereo point triangulator: top level with config registers, pipeline and output stage.
// Pipeline: 3 front stages + DivSteps divider stages + 1 output stage.
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a downstream stall freezes every stage.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Dropped words leave an empty slot in the pipeline and produce no result.
module stereo_point_triangulator #(
    parameter int unsigned DivSteps = spt_pkg::DefDivSteps
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [13:0] i_left_x,
    input  logic [13:0] i_right_x,
    input  logic [13:0] i_left_y,
    input  logic [13:0] i_right_y,
    input  logic [31:0] i_frame_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_depth_mm,
    output logic signed [15:0] o_lateral_mm,
    output logic signed [15:0] o_vertical_mm,
    output logic [31:0] o_tag_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned NW = spt_pkg::NumW;
    localparam int unsigned DW = spt_pkg::DenW;
    localparam int unsigned QW = spt_pkg::QuoW;

    spt_pkg::t_cfg r_cfg;
    logic w_en;

    // Configuration registers; writes are always accepted.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{focal: 16'd8868, base: 11'd200, cx: 14'd5120, cy: 14'd2880,
                       jit: 14'd240, margin: 14'd800, width: 14'd10240};
        end else if (i_cfg_valid) begin
            unique case (spt_pkg::t_reg_idx'(i_cfg_index))
                spt_pkg::REG_FOCAL:  r_cfg.focal  <= i_cfg_data;
                spt_pkg::REG_BASE:   r_cfg.base   <= i_cfg_data[10:0];
                spt_pkg::REG_CX:     r_cfg.cx     <= i_cfg_data[13:0];
                spt_pkg::REG_CY:     r_cfg.cy     <= i_cfg_data[13:0];
                spt_pkg::REG_JIT:    r_cfg.jit    <= i_cfg_data[13:0];
                spt_pkg::REG_MARGIN: r_cfg.margin <= i_cfg_data[13:0];
                spt_pkg::REG_WIDTH:  r_cfg.width  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one; it holds only when a result is waiting and stalled.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    logic              w_fv;
    logic [NW-1:0]     w_nz, w_nx, w_ny;
    logic [DW-1:0]     w_dxz, w_dy;
    logic [2:0]        w_neg;
    logic [31:0]       w_tag;

    spt_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid, .i_cfg(r_cfg),
        .i_lx(i_left_x), .i_rx(i_right_x), .i_ly(i_left_y), .i_ry(i_right_y),
        .i_tag(i_frame_tag), .o_valid(w_fv), .o_num_z(w_nz), .o_num_x(w_nx),
        .o_num_y(w_ny), .o_den_xz(w_dxz), .o_den_y(w_dy), .o_neg(w_neg),
        .o_tag(w_tag)
    );

    logic [QW-1:0] w_qz, w_qx, w_qy;
    spt_divider #(.Steps(DivSteps)) u_div_z (
        .i_clk, .i_en(w_en), .i_num(w_nz), .i_den(w_dxz), .o_quo(w_qz));
    spt_divider #(.Steps(DivSteps)) u_div_x (
        .i_clk, .i_en(w_en), .i_num(w_nx), .i_den(w_dxz), .o_quo(w_qx));
    spt_divider #(.Steps(DivSteps)) u_div_y (
        .i_clk, .i_en(w_en), .i_num(w_ny), .i_den(w_dy), .o_quo(w_qy));

    // Valid, signs and tag ride alongside the divider stages.
    logic        r_dv  [DivSteps+1];
    logic [1:0]  r_sg  [DivSteps+1];
    logic [31:0] r_tg  [DivSteps+1];
    always_comb begin
        r_dv[0] = w_fv;
        r_sg[0] = w_neg[2:1];
        r_tg[0] = w_tag;
    end
    for (genvar s = 0; s < DivSteps; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sg[s+1] <= r_sg[s];
                r_tg[s+1] <= r_tg[s];
            end
        end
    end

    // Sign restore and saturation into the output register.
    function automatic logic [15:0] sat_s16(input logic [QW-1:0] mag, input logic neg);
        logic [15:0] res;
        if (neg) begin
            res = (mag > QW'(32768)) ? 16'h8000 : 16'(-mag);
        end else begin
            res = (mag > QW'(32767)) ? 16'h7FFF : mag[15:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_dv[DivSteps];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_depth_mm    <= (w_qz > QW'(65535)) ? 16'hFFFF : w_qz[15:0];
            o_lateral_mm  <= sat_s16(w_qx, r_sg[DivSteps][0]);
            o_vertical_mm <= sat_s16(w_qy, r_sg[DivSteps][1]);
            o_tag_out     <= r_tg[DivSteps];
        end
    end
endmodule

/* hw/rtl/spt_divider.sv */
// Pipelined restoring divider with round-half-up on magnitudes, several bits per stage.
module spt_divider #(
    parameter int unsigned Steps = spt_pkg::DefDivSteps
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [spt_pkg::NumW-1:0]   i_num,
    input  logic [spt_pkg::DenW-1:0]   i_den,
    output logic [spt_pkg::QuoW-1:0]   o_quo
);
    // Computes floor((2*n + den) / (2*den)); i_num here is already 2*n+den.
    localparam int unsigned NW = spt_pkg::NumW;
    localparam int unsigned DW = spt_pkg::DenW + 1;
    localparam int unsigned BitsPer = (NW + Steps - 1) / Steps;
    localparam int unsigned TotBits = BitsPer * Steps;

    logic [TotBits-1:0] r_n   [Steps+1];
    logic [DW-1:0]      r_rem [Steps+1];
    logic [DW-1:0]      r_den [Steps+1];

    always_comb begin
        r_n[0]   = TotBits'(i_num);
        r_rem[0] = '0;
        r_den[0] = {i_den, 1'b0};
    end

    for (genvar s = 0; s < Steps; s++) begin : g_stage
        logic [TotBits-1:0] n_n;
        logic [DW-1:0]      n_rem;
        logic [DW:0]        w_trial;
        logic [DW-1:0]      w_rem;
        logic [TotBits-1:0] w_n;
        always_comb begin
            w_rem = r_rem[s];
            w_n   = r_n[s];
            w_trial = '0;
            for (int k = 0; k < BitsPer; k++) begin
                w_trial = {w_rem, w_n[TotBits-1]} - {1'b0, r_den[s]};
                w_n = {w_n[TotBits-2:0], ~w_trial[DW]};
                if (!w_trial[DW]) begin
                    w_rem = w_trial[DW-1:0];
                end else begin
                    w_rem = {w_rem[DW-2:0], r_n[s][TotBits-1-k]};
                end
            end
            n_n   = w_n;
            n_rem = w_rem;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= n_n;
                r_rem[s+1] <= n_rem;
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign o_quo = spt_pkg::QuoW'(r_n[Steps]);
endmodule

/* hw/rtl/spt_front.sv */
// Front stages: gating checks, products and rounding numerators.
module spt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  spt_pkg::t_cfg               i_cfg,
    input  logic [spt_pkg::CoordW-1:0]  i_lx,
    input  logic [spt_pkg::CoordW-1:0]  i_rx,
    input  logic [spt_pkg::CoordW-1:0]  i_ly,
    input  logic [spt_pkg::CoordW-1:0]  i_ry,
    input  logic [spt_pkg::TagW-1:0]    i_tag,
    output logic                        o_valid,
    output logic [spt_pkg::NumW-1:0]    o_num_z,
    output logic [spt_pkg::NumW-1:0]    o_num_x,
    output logic [spt_pkg::NumW-1:0]    o_num_y,
    output logic [spt_pkg::DenW-1:0]    o_den_xz,
    output logic [spt_pkg::DenW-1:0]    o_den_y,
    output logic [2:0]                  o_neg,
    output logic [spt_pkg::TagW-1:0]    o_tag
);
    localparam int unsigned CW = spt_pkg::CoordW;
    localparam int unsigned NW = spt_pkg::NumW;
    localparam int unsigned DW = spt_pkg::DenW;

    // Stage 1: checks, disparity, signed offsets.
    logic              r_v1;
    logic [CW-1:0]     r_d1;
    logic signed [CW+1:0] r_ox1;
    logic signed [CW+2:0] r_oy1;
    logic [15:0]       r_f1;
    logic [10:0]       r_b1;
    logic [spt_pkg::TagW-1:0] r_t1;

    logic signed [CW+1:0] w_hi, w_d, w_dy;
    logic w_ok;
    always_comb begin
        w_hi = $signed({2'b00, i_cfg.width}) - $signed({2'b00, i_cfg.margin});
        w_d  = $signed({2'b00, i_lx}) - $signed({2'b00, i_rx});
        w_dy = $signed({2'b00, i_ly}) - $signed({2'b00, i_ry});
        if (w_dy < 0) w_dy = -w_dy;
        w_ok = (i_lx >= i_cfg.margin) && ($signed({2'b00, i_lx}) <= w_hi)
            && (i_rx >= i_cfg.margin) && ($signed({2'b00, i_rx}) <= w_hi)
            && (w_dy <= $signed({2'b00, i_cfg.jit}))
            && (w_d > $signed((CW+2)'(8)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid && w_ok;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1  <= w_d[CW-1:0];
            r_ox1 <= $signed({2'b00, i_lx}) - $signed({2'b00, i_cfg.cx});
            r_oy1 <= $signed({3'b000, i_ly}) + $signed({3'b000, i_ry})
                   - $signed({2'b00, i_cfg.cy, 1'b0});
            r_f1  <= i_cfg.focal;
            r_b1  <= i_cfg.base;
            r_t1  <= i_tag;
        end
    end

    // Stage 2: multiplications on magnitudes.
    logic          r_v2;
    logic [CW-1:0] r_d2;
    logic [26:0]   r_pz2, r_px2, r_py2;
    logic [1:0]    r_s2;
    logic [spt_pkg::TagW-1:0] r_t2;
    logic [CW+1:0] w_ax;
    logic [CW+2:0] w_ay;
    always_comb begin
        w_ax = r_ox1[CW+1] ? -r_ox1 : r_ox1;
        w_ay = r_oy1[CW+2] ? -r_oy1 : r_oy1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2  <= r_d1;
            r_pz2 <= r_f1 * r_b1;
            r_px2 <= 27'(w_ax * r_b1);
            r_py2 <= 27'(w_ay * r_b1);
            r_s2  <= {r_oy1[CW+2], r_ox1[CW+1]};
            r_t2  <= r_t1;
        end
    end

    // Stage 3: rounding numerators 2*mag + den.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num_z  <= NW'({r_pz2, 1'b0}) + NW'(r_d2);
            o_num_x  <= NW'({r_px2, 1'b0}) + NW'(r_d2);
            o_num_y  <= NW'({r_py2, 1'b0}) + NW'({r_d2, 1'b0});
            o_den_xz <= DW'(r_d2);
            o_den_y  <= DW'({r_d2, 1'b0});
            o_neg    <= {r_s2, 1'b0};
            o_tag    <= r_t2;
        end
    end
endmodule

/* hw/rtl/spt_checker.sv */
// Port-level checker for the stereo point triangulator, bound to the top level.
module spt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_depth_mm,
    input logic [31:0] o_tag_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tag_out) && $stable(o_depth_mm))
        else $error("stalled result word changed");
    a_nostall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no pending result");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stall without output stall");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind stereo_point_triangulator spt_checker u_spt_checker (.*);

/* tb/spt_checker.sv */
// Checker for the stereo point triangulator: mirrors the registers, predicts results, compares.
module spt_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [13:0]        i_left_x,
    input  logic [13:0]        i_right_x,
    input  logic [13:0]        i_left_y,
    input  logic [13:0]        i_right_y,
    input  logic [31:0]        i_frame_tag,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_depth_mm,
    input  logic signed [15:0] i_lateral_mm,
    input  logic signed [15:0] i_vertical_mm,
    input  logic [31:0]        i_tag_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_points
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] depth;
        logic [15:0] lateral;
        logic [15:0] vertical;
        logic [31:0] tag;
    } t_point;

    spt_pkg::t_cfg cam;
    t_point        points_due[$];

    function automatic longint round_div(longint n, longint den);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag * 2 + den) / (2 * den);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] clip_s16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic bit off_image(longint x);
        return x < longint'(cam.margin) || x > longint'(cam.width) - longint'(cam.margin);
    endfunction

    // Returns 1 and fills the point when the detection survives the gating.
    function automatic bit triangulate(input logic [13:0] lx, rx, ly, ry,
                                       input logic [31:0] tag, output t_point p);
        longint dy, d, z, b;
        p = '0;
        if (off_image(lx) || off_image(rx)) return 0;
        dy = longint'(ly) - longint'(ry);
        if (dy < 0) dy = -dy;
        if (dy > longint'(cam.jit)) return 0;
        d = longint'(lx) - longint'(rx);
        if (d <= 8) return 0;
        b = cam.base;
        z = round_div(longint'(cam.focal) * b, d);
        if (z > 65535) z = 65535;
        p.depth    = z[15:0];
        p.lateral  = clip_s16(round_div((longint'(lx) - longint'(cam.cx)) * b, d));
        p.vertical = clip_s16(round_div((longint'(ly) + longint'(ry)
                                         - 2 * longint'(cam.cy)) * b, 2 * d));
        p.tag      = tag;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_point p;
        t_point want;
        if (!i_rst_n) begin
            cam <= '{focal: 16'd8868, base: 11'd200, cx: 14'd5120, cy: 14'd2880,
                     jit: 14'd240, margin: 14'd800, width: 14'd10240};
            points_due.delete();
            o_errors  <= 0;
            o_points  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (spt_pkg::t_reg_idx'(i_cfg_index))
                    spt_pkg::REG_FOCAL:  cam.focal  <= i_cfg_data;
                    spt_pkg::REG_BASE:   cam.base   <= i_cfg_data[10:0];
                    spt_pkg::REG_CX:     cam.cx     <= i_cfg_data[13:0];
                    spt_pkg::REG_CY:     cam.cy     <= i_cfg_data[13:0];
                    spt_pkg::REG_JIT:    cam.jit    <= i_cfg_data[13:0];
                    spt_pkg::REG_MARGIN: cam.margin <= i_cfg_data[13:0];
                    spt_pkg::REG_WIDTH:  cam.width  <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (triangulate(i_left_x, i_right_x, i_left_y, i_right_y, i_frame_tag, p))
                    points_due.push_back(p);
            end
            if (i_out_valid && !i_out_stall) begin
                o_points <= o_points + 1;
                if (points_due.size() == 0) begin
                    if (o_errors < 10) $display("checker: result with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = points_due.pop_front();
                    if (want !== {i_depth_mm, i_lateral_mm, i_vertical_mm, i_tag_out}) begin
                        if (o_errors < 10)
                            $display("checker: expected z=%0d x=%0d y=%0d tag=%h, got z=%0d x=%0d y=%0d tag=%h",
                                     want.depth, $signed(want.lateral), $signed(want.vertical),
                                     want.tag, i_depth_mm, i_lateral_mm, i_vertical_mm,
                                     i_tag_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= points_due.size();
        end
    end
endmodule

/* tb/tb.sv */
// Top of the stereo point triangulator testbench: stimulus, stall patterns and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [13:0] i_left_x = '0, i_right_x = '0, i_left_y = '0, i_right_y = '0;
    logic [31:0] i_frame_tag = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_depth_mm;
    logic signed [15:0] o_lateral_mm, o_vertical_mm;
    logic [31:0] o_tag_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int errors, pending, points;
    int cycles = 0;
    int words_sent = 0;
    bit hold_off = 1'b0;

    // Camera settings the stimulus aims at; kept in step with the register writes.
    int m_now = 800, w_now = 10240, j_now = 240;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    stereo_point_triangulator dut (.*);

    spt_scoreboard chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_left_x, .i_right_x, .i_left_y, .i_right_y, .i_frame_tag,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_depth_mm(o_depth_mm), .i_lateral_mm(o_lateral_mm),
        .i_vertical_mm(o_vertical_mm), .i_tag_out(o_tag_out),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_points(points)
    );

    // The limit covers 896 words under the worst gaps and stalls, many times over.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: timeout with %0d results outstanding", pending);
            $display("tb: done, errors");
            $finish;
        end
    end

    // The receiver stalls in short random runs, and during a hold-off it stalls outright
    // so that the pipeline fills and the input is pushed back.
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (($urandom & 32'd7) < 3) i_stall <= 1'b1;
        else if (($urandom & 32'd3) == 0) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 9) < 2);
    end

    initial begin
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // One register write; an idle cycle ahead of it keeps consecutive writes apart.
    task automatic write_reg(spt_pkg::t_reg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            spt_pkg::REG_MARGIN: m_now = val[13:0];
            spt_pkg::REG_WIDTH:  w_now = val[13:0];
            spt_pkg::REG_JIT:    j_now = val[13:0];
            default: ;
        endcase
    endtask

    // Offers one word and waits until the block takes it. Valid stays high between
    // back-to-back words, so it is only lowered by the caller's gap or settle.
    task automatic send_word(logic [13:0] lx, rx, ly, ry, logic [31:0] tag);
        i_valid     <= 1'b1;
        i_left_x    <= lx;
        i_right_x   <= rx;
        i_left_y    <= ly;
        i_right_y   <= ry;
        i_frame_tag <= tag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drains the pipeline before a register write: waits for all expected results first,
    // then waits longer for any dropped word still in flight.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // Random word, mostly a well-formed detection inside the image with small jitter
    // and non-negative disparity; the rest is full-range noise.
    task automatic random_word();
        int lo, hi, lx, rx, ly, ry;
        lo = m_now;
        hi = w_now - m_now;
        if ($urandom_range(0, 9) < 8 && hi > lo + 10) begin
            lx = $urandom_range(hi, lo);
            rx = lx - $urandom_range(0, (lx - lo < 600) ? lx - lo : 600);
            ly = $urandom_range(0, 16383);
            ry = ly + $urandom_range(0, 2 * j_now + 2) - j_now - 1;
            if (ry < 0) ry = 0;
            if (ry > 16383) ry = 16383;
        end else begin
            lx = $urandom_range(0, 16383);
            rx = $urandom_range(0, 16383);
            ly = $urandom_range(0, 16383);
            ry = $urandom_range(0, 16383);
        end
        send_word(14'(lx), 14'(rx), 14'(ly), 14'(ry), $urandom);
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0) begin
                random_word();
                burst--;
                n--;
            end
            gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: centre, border edges, jitter edges,
        // disparity at and just past the gating threshold of 8, extreme fields.
        send_word(14'd6000, 14'd5000, 14'd2880, 14'd2880, 32'h0);
        send_word(14'd800, 14'd700, 14'd0, 14'd0, 32'hFFFF_FFFF);
        send_word(14'd9440, 14'd800, 14'd16383, 14'd16383, 32'h1);
        send_word(14'd9441, 14'd900, 14'd100, 14'd100, 32'h2);
        send_word(14'd799, 14'd500, 14'd100, 14'd100, 32'h3);
        send_word(14'd5000, 14'd4992, 14'd100, 14'd100, 32'h4);
        send_word(14'd5000, 14'd4991, 14'd100, 14'd100, 32'h5);
        send_word(14'd5000, 14'd5100, 14'd100, 14'd100, 32'h6);
        send_word(14'd5000, 14'd4000, 14'd1000, 14'd1240, 32'h7);
        send_word(14'd5000, 14'd4000, 14'd1241, 14'd1000, 32'h8);
        send_word(14'd16383, 14'd16383, 14'd0, 14'd16383, 32'h9);
        send_word(14'd0, 14'd0, 14'd0, 14'd0, 32'hA);
        settle();

        // Extremes: huge focal and baseline push many results into saturation; no margin, full width.
        write_reg(spt_pkg::REG_FOCAL, 16'hFFFF);
        write_reg(spt_pkg::REG_BASE, 16'd2000);
        write_reg(spt_pkg::REG_CX, 16'd0);
        write_reg(spt_pkg::REG_CY, 16'd16383);
        write_reg(spt_pkg::REG_JIT, 16'd16383);
        write_reg(spt_pkg::REG_MARGIN, 16'd0);
        write_reg(spt_pkg::REG_WIDTH, 16'd16383);
        send_word(14'd16383, 14'd0, 14'd0, 14'd0, 32'hB);
        send_word(14'd9, 14'd0, 14'd16383, 14'd0, 32'hC);
        send_word(14'd16383, 14'd16374, 14'd0, 14'd0, 32'hD);
        random_phase(150);
        settle();

        // Zero focal length and zero baseline; an unknown index is ignored.
        write_reg(spt_pkg::REG_FOCAL, 16'd0);
        write_reg(spt_pkg::REG_BASE, 16'd0);
        write_reg(spt_pkg::t_reg_idx'(3'd7), 16'hFFFF);
        send_word(14'd9000, 14'd100, 14'd50, 14'd60, 32'hE);
        random_phase(60);
        settle();
        write_reg(spt_pkg::REG_BASE, 16'd1);
        random_phase(60);
        settle();

        // Margin wider than the image: everything dropped.
        write_reg(spt_pkg::REG_FOCAL, 16'd1);
        write_reg(spt_pkg::REG_MARGIN, 16'd9000);
        write_reg(spt_pkg::REG_WIDTH, 16'd1);
        random_phase(40);
        settle();

        // Narrow margin, tiny jitter, middling optics.
        write_reg(spt_pkg::REG_FOCAL, 16'd12000);
        write_reg(spt_pkg::REG_BASE, 16'd777);
        write_reg(spt_pkg::REG_CX, 16'd8191);
        write_reg(spt_pkg::REG_CY, 16'd4000);
        write_reg(spt_pkg::REG_JIT, 16'd0);
        write_reg(spt_pkg::REG_MARGIN, 16'd16);
        write_reg(spt_pkg::REG_WIDTH, 16'd16000);
        random_phase(150);
        settle();

        // Back to the reset settings for the bulk of the run.
        write_reg(spt_pkg::REG_FOCAL, 16'd8868);
        write_reg(spt_pkg::REG_BASE, 16'd200);
        write_reg(spt_pkg::REG_CX, 16'd5120);
        write_reg(spt_pkg::REG_CY, 16'd2880);
        write_reg(spt_pkg::REG_JIT, 16'd240);
        write_reg(spt_pkg::REG_MARGIN, 16'd800);
        write_reg(spt_pkg::REG_WIDTH, 16'd10240);
        random_phase(420);

        settle();
        $display("tb: %0d words sent, %0d results checked over seven camera settings",
                 words_sent, points);
        $display("tb: covered border, jitter, disparity gating, saturation and zero optics");
        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule
